/* hw/rtl/h264_rtp_fu_a_packetizer_unit_macros.svh */
// Assertion macros used by the packetizer checker.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef H264_RTP_FU_A_PACKETIZER_UNIT_MACROS_SVH
`define H264_RTP_FU_A_PACKETIZER_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define FUA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define FUA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fua_pkg.sv */
// Shared widths, constants, register indexes and transaction types of the packetizer.
// No dependencies; fua_front, fua_back, the top level and the checker import it.
`timescale 1ns / 1ps

package fua_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FRAG_W     = 14;
  localparam int unsigned LEN_W      = 24;
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned TS_W       = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [FRAG_W-1:0] FRAG_MIN   = 14'd2;
  localparam logic [FRAG_W-1:0] FRAG_MAX   = 14'd8192;
  localparam logic [FRAG_W-1:0] FRAG_RESET = 14'd1400;
  localparam logic [TS_W-1:0]   STEP_RESET = 32'(90000 / 25);
  localparam logic [SEQ_W-1:0]  SEQ_RESET  = '0;
  localparam logic [TS_W-1:0]   TS_RESET   = '0;

  localparam logic [4:0]        FU_A_TYPE  = 5'd28;
  localparam logic [4:0]        TYPE_SPS   = 5'd7;
  localparam logic [4:0]        TYPE_PPS   = 5'd8;
  localparam logic [BYTE_W-1:0] NRI_MASK   = 8'h60;
  localparam logic [BYTE_W-1:0] TYPE_MASK  = 8'h1F;
  localparam logic [BYTE_W-1:0] START_BIT  = 8'h80;
  localparam logic [BYTE_W-1:0] END_BIT    = 8'h40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAG_SIZE,
    REG_TS_STEP,
    REG_SEQ_START,
    REG_TS_START
  } cfg_reg_t;

  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // One accepted NAL byte that gives results: the data byte, optionally
  // preceded by an FU indicator and an FU header.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              hdr_en;
    logic [BYTE_W-1:0] ind_byte;
    logic [BYTE_W-1:0] fuh_byte;
    logic              pkt_first;
    logic              pkt_last;
    logic [FRAG_W-1:0] pkt_bytes;
    logic [SEQ_W-1:0]  seq;
    logic [TS_W-1:0]   ts;
  } job_t;

  localparam int unsigned JOB_W = $bits(job_t);

endpackage

/* hw/rtl/fua_queue.sv */
// Small first-in first-out queue of registers between front and back end.
// Generic: width and depth by parameter, no package needed.
`timescale 1ns / 1ps

module fua_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hw/rtl/fua_front.sv */
// Front end: configuration registers, NAL tracking, sequence and timestamp.
// Classifies each accepted byte into a queue transaction. Uses fua_pkg.
`timescale 1ns / 1ps

module fua_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fua_pkg::cfg_wr_t              cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fua_pkg::BYTE_W-1:0]    in_nal_byte,
  input  logic                          in_nal_first,
  input  logic [fua_pkg::LEN_W-1:0]     in_nal_length,
  output logic                          job_valid,
  input  logic                          job_ready,
  output fua_pkg::job_t                 job
);

  import fua_pkg::*;

  logic              frag_mode_r, frag_mode_nxt;
  logic [LEN_W-1:0]  left_nal_r, left_nal_nxt;
  logic [FRAG_W-1:0] left_frag_r, left_frag_nxt;
  logic [BYTE_W-1:0] saved_hdr_r, saved_hdr_nxt;
  logic              first_due_r, first_due_nxt;
  logic [FRAG_W-1:0] pkt_len_r, pkt_len_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [TS_W-1:0]   ts_r, ts_nxt;
  logic [FRAG_W-1:0] frag_size_r, frag_size_nxt;
  logic [TS_W-1:0]   ts_step_r, ts_step_nxt;

  logic              accept;
  logic              emit;
  logic [LEN_W-1:0]  len0;
  logic [LEN_W-1:0]  frag_ext;
  logic              fits;
  logic              is_end;
  logic [FRAG_W-1:0] chunk;
  logic [FRAG_W-1:0] frag_cnt;
  logic              saved_ps;
  logic              new_ps;
  logic [FRAG_W-1:0] cfg_frag;

  assign in_ready  = job_ready;
  assign accept    = in_valid && in_ready;
  assign job_valid = in_valid && emit;

  assign len0     = (in_nal_length == '0) ? LEN_W'(1) : in_nal_length;
  assign frag_ext = {{(LEN_W - FRAG_W){1'b0}}, frag_size_r};
  assign fits     = (len0 <= frag_ext);
  assign is_end   = (left_nal_r <= frag_ext);
  assign chunk    = is_end ? left_nal_r[FRAG_W-1:0] : frag_size_r;
  assign frag_cnt = (left_frag_r == '0) ? chunk : left_frag_r;
  assign saved_ps = (saved_hdr_r[4:0] == TYPE_SPS) || (saved_hdr_r[4:0] == TYPE_PPS);
  assign new_ps   = (in_nal_byte[4:0] == TYPE_SPS) || (in_nal_byte[4:0] == TYPE_PPS);
  assign cfg_frag = cfg.data[FRAG_W-1:0];

  always_comb begin
    frag_mode_nxt = frag_mode_r;
    left_nal_nxt  = left_nal_r;
    left_frag_nxt = left_frag_r;
    saved_hdr_nxt = saved_hdr_r;
    first_due_nxt = first_due_r;
    pkt_len_nxt   = pkt_len_r;
    seq_nxt       = seq_r;
    ts_nxt        = ts_r;
    frag_size_nxt = frag_size_r;
    ts_step_nxt   = ts_step_r;
    emit          = 1'b0;
    job.data_byte = in_nal_byte;
    job.hdr_en    = 1'b0;
    job.ind_byte  = (saved_hdr_r & NRI_MASK) | {3'b000, FU_A_TYPE};
    job.fuh_byte  = (saved_hdr_r & TYPE_MASK) | (first_due_r ? START_BIT : '0)
                    | (is_end ? END_BIT : '0);
    job.pkt_first = 1'b0;
    job.pkt_last  = 1'b0;
    job.pkt_bytes = pkt_len_r;
    job.seq       = seq_r;
    job.ts        = ts_r;

    if (in_valid && in_nal_first) begin
      // Header byte: open a new NAL, dropping any unfinished one.
      emit = fits;
      if (accept) begin
        saved_hdr_nxt = in_nal_byte;
        left_nal_nxt  = len0 - 1'b1;
        left_frag_nxt = '0;
        first_due_nxt = 1'b1;
        frag_mode_nxt = !fits;
        pkt_len_nxt   = fits ? len0[FRAG_W-1:0] : '0;
        if (fits && (len0 == LEN_W'(1))) begin
          seq_nxt = seq_r + 1'b1;
          if (!new_ps) begin
            ts_nxt = ts_r + ts_step_r;
          end
        end
      end
      job.pkt_first = 1'b1;
      job.pkt_last  = (len0 == LEN_W'(1));
      job.pkt_bytes = len0[FRAG_W-1:0];
    end else if (in_valid && (left_nal_r != '0)) begin
      emit = 1'b1;
      if (!frag_mode_r) begin
        job.pkt_last = (left_nal_r == LEN_W'(1));
        if (accept) begin
          left_nal_nxt = left_nal_r - 1'b1;
          if (left_nal_r == LEN_W'(1)) begin
            seq_nxt = seq_r + 1'b1;
            if (!saved_ps) begin
              ts_nxt = ts_r + ts_step_r;
            end
          end
        end
      end else begin
        // Fragment start: prepend indicator and FU header.
        if (left_frag_r == '0) begin
          job.hdr_en    = 1'b1;
          job.pkt_bytes = chunk + FRAG_W'(2);
        end
        job.pkt_last = (frag_cnt == FRAG_W'(1));
        if (accept) begin
          left_nal_nxt  = left_nal_r - 1'b1;
          left_frag_nxt = frag_cnt - 1'b1;
          if (left_frag_r == '0) begin
            first_due_nxt = 1'b0;
            pkt_len_nxt   = chunk + FRAG_W'(2);
          end
          if (frag_cnt == FRAG_W'(1)) begin
            seq_nxt = seq_r + 1'b1;
          end
          if (left_nal_r == LEN_W'(1)) begin
            ts_nxt = ts_r + ts_step_r;
          end
        end
      end
    end

    // The user must issue register writes only while idle; the block does not enforce it.
    if (cfg.wr) begin
      case (cfg_reg_t'(cfg.idx))
        REG_FRAG_SIZE: begin
          if (cfg_frag < FRAG_MIN) begin
            frag_size_nxt = FRAG_MIN;
          end else if (cfg_frag > FRAG_MAX) begin
            frag_size_nxt = FRAG_MAX;
          end else begin
            frag_size_nxt = cfg_frag;
          end
        end
        REG_TS_STEP:   ts_step_nxt = cfg.data[TS_W-1:0];
        REG_SEQ_START: seq_nxt     = cfg.data[SEQ_W-1:0];
        REG_TS_START:  ts_nxt      = cfg.data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frag_mode_r <= 1'b0;
      left_nal_r  <= '0;
      left_frag_r <= '0;
      saved_hdr_r <= '0;
      first_due_r <= 1'b0;
      pkt_len_r   <= '0;
      seq_r       <= SEQ_RESET;
      ts_r        <= TS_RESET;
      frag_size_r <= FRAG_RESET;
      ts_step_r   <= STEP_RESET;
    end else begin
      frag_mode_r <= frag_mode_nxt;
      left_nal_r  <= left_nal_nxt;
      left_frag_r <= left_frag_nxt;
      saved_hdr_r <= saved_hdr_nxt;
      first_due_r <= first_due_nxt;
      pkt_len_r   <= pkt_len_nxt;
      seq_r       <= seq_nxt;
      ts_r        <= ts_nxt;
      frag_size_r <= frag_size_nxt;
      ts_step_r   <= ts_step_nxt;
    end
  end

endmodule

/* hw/rtl/fua_back.sv */
// Back end: expands queued transactions into one or three payload bytes.
// Owns the output register. Uses fua_pkg.
`timescale 1ns / 1ps

module fua_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       job_valid,
  output logic                       job_ready,
  input  fua_pkg::job_t              job,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fua_pkg::BYTE_W-1:0] out_packet_byte,
  output logic                       out_packet_first,
  output logic                       out_packet_last,
  output logic [fua_pkg::FRAG_W-1:0] out_packet_bytes,
  output logic [fua_pkg::SEQ_W-1:0]  out_sequence_number,
  output logic [fua_pkg::TS_W-1:0]   out_rtp_timestamp,
  output logic                       out_run_last
);

  import fua_pkg::*;

  typedef enum logic [1:0] {
    BEAT_IND,
    BEAT_FUH,
    BEAT_DATA
  } beat_t;

  beat_t             beat_r, beat_nxt;
  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              first_r, first_nxt;
  logic              last_r, last_nxt;
  logic [FRAG_W-1:0] bytes_r, bytes_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [TS_W-1:0]   ts_r, ts_nxt;
  logic              run_last_r, run_last_nxt;
  logic              load;

  assign load = !valid_r || out_ready;

  always_comb begin
    beat_nxt     = beat_r;
    valid_nxt    = valid_r && !out_ready;
    byte_nxt     = byte_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    bytes_nxt    = bytes_r;
    seq_nxt      = seq_r;
    ts_nxt       = ts_r;
    run_last_nxt = run_last_r;
    job_ready    = 1'b0;
    if (load && job_valid) begin
      valid_nxt = 1'b1;
      bytes_nxt = job.pkt_bytes;
      seq_nxt   = job.seq;
      ts_nxt    = job.ts;
      case (beat_r)
        BEAT_IND: begin
          if (job.hdr_en) begin
            byte_nxt     = job.ind_byte;
            first_nxt    = 1'b1;
            last_nxt     = 1'b0;
            run_last_nxt = 1'b0;
            beat_nxt     = BEAT_FUH;
          end else begin
            byte_nxt     = job.data_byte;
            first_nxt    = job.pkt_first;
            last_nxt     = job.pkt_last;
            run_last_nxt = 1'b1;
            job_ready    = 1'b1;
          end
        end
        BEAT_FUH: begin
          byte_nxt     = job.fuh_byte;
          first_nxt    = 1'b0;
          last_nxt     = 1'b0;
          run_last_nxt = 1'b0;
          beat_nxt     = BEAT_DATA;
        end
        default: begin
          byte_nxt     = job.data_byte;
          first_nxt    = 1'b0;
          last_nxt     = job.pkt_last;
          run_last_nxt = 1'b1;
          job_ready    = 1'b1;
          beat_nxt     = BEAT_IND;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r  <= BEAT_IND;
      valid_r <= 1'b0;
    end else begin
      beat_r  <= beat_nxt;
      valid_r <= valid_nxt;
    end
    byte_r     <= byte_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    bytes_r    <= bytes_nxt;
    seq_r      <= seq_nxt;
    ts_r       <= ts_nxt;
    run_last_r <= run_last_nxt;
  end

  assign out_valid           = valid_r;
  assign out_packet_byte     = byte_r;
  assign out_packet_first    = first_r;
  assign out_packet_last     = last_r;
  assign out_packet_bytes    = bytes_r;
  assign out_sequence_number = seq_r;
  assign out_rtp_timestamp   = ts_r;
  assign out_run_last        = run_last_r;

endmodule

/* hw/rtl/h264_rtp_fu_a_packetizer_unit.sv */
// Top level of the H.264 RTP packetizer (single NAL unit and FU-A modes).
// Instantiates fua_front, fua_queue and fua_back; uses fua_pkg.
//
// Use:
//   in_*  : one NAL byte per transaction, start code removed. Raise in_nal_first
//           on the header byte and give the total NAL length with it.
//   out_* : RTP payload bytes. out_packet_first/out_packet_last frame a packet,
//           out_packet_bytes, out_sequence_number and out_rtp_timestamp stand on
//           every byte; out_run_last marks the last byte caused by one input.
//   cfg_* : register writes (fragment size, timestamp step, sequence start,
//           timestamp start); always ready, issue them only while idle.
// Path: an accepted byte is written into the queue, then into the output register.
// Throughput: one byte per cycle while the queue has room. The first data byte of
//   each FU-A fragment gives three output bytes, so input slows in long NALs; the
//   four-entry queue absorbs the extra beats. The output register is the only
//   limit on the back end: one byte a cycle while out_ready is high.
// Reset: synchronous, active low. Clears the NAL state, loads the reset register
//   values, sequence 0 and timestamp 0, and empties the queue. No clearing pass.
// Stall: when out_ready is low the output byte holds; the queue then fills and
//   in_ready falls until the receiver takes data again.
`timescale 1ns / 1ps

module h264_rtp_fu_a_packetizer_unit #(
  parameter int unsigned QUEUE_DEPTH = fua_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fua_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fua_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fua_pkg::BYTE_W-1:0]     in_nal_byte,
  input  logic                           in_nal_first,
  input  logic [fua_pkg::LEN_W-1:0]      in_nal_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fua_pkg::BYTE_W-1:0]     out_packet_byte,
  output logic                           out_packet_first,
  output logic                           out_packet_last,
  output logic [fua_pkg::FRAG_W-1:0]     out_packet_bytes,
  output logic [fua_pkg::SEQ_W-1:0]      out_sequence_number,
  output logic [fua_pkg::TS_W-1:0]       out_rtp_timestamp,
  output logic                           out_run_last
);

  import fua_pkg::*;

  cfg_wr_t          cfg;
  logic             push_valid, push_ready;
  job_t             push_job;
  logic             pop_valid, pop_ready;
  logic [JOB_W-1:0] pop_data;
  job_t             pop_job;

  // Register writes never stall.
  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid && cfg_ready;
  assign cfg.idx   = cfg_index;
  assign cfg.data  = cfg_data;

  // Front: classify each byte and keep per-NAL state.
  fua_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_nal_byte   (in_nal_byte),
    .in_nal_first  (in_nal_first),
    .in_nal_length (in_nal_length),
    .job_valid     (push_valid),
    .job_ready     (push_ready),
    .job           (push_job)
  );

  // Decouple the front from header insertion in the back end.
  fua_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_job),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  assign pop_job = pop_data;

  // Back: emit indicator, FU header and data bytes into the output register.
  fua_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_valid           (pop_valid),
    .job_ready           (pop_ready),
    .job                 (pop_job),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_packet_byte     (out_packet_byte),
    .out_packet_first    (out_packet_first),
    .out_packet_last     (out_packet_last),
    .out_packet_bytes    (out_packet_bytes),
    .out_sequence_number (out_sequence_number),
    .out_rtp_timestamp   (out_rtp_timestamp),
    .out_run_last        (out_run_last)
  );

endmodule

/* hw/rtl/fua_checker.sv */
// Port-level checks of the packetizer, bound to the top level.
// Uses fua_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "h264_rtp_fu_a_packetizer_unit_macros.svh"

module fua_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [fua_pkg::BYTE_W-1:0]     out_packet_byte,
  input logic                           out_packet_first,
  input logic                           out_packet_last,
  input logic [fua_pkg::FRAG_W-1:0]     out_packet_bytes,
  input logic [fua_pkg::SEQ_W-1:0]      out_sequence_number,
  input logic [fua_pkg::TS_W-1:0]       out_rtp_timestamp,
  input logic                           out_run_last
);

  import fua_pkg::*;

  logic                                 out_stall;
  logic [BYTE_W+FRAG_W+SEQ_W+TS_W+2:0]  out_beat;
  logic                                 ind_ok;

  assign out_stall = out_valid && !out_ready;
  assign out_beat  = {out_packet_byte, out_packet_first, out_packet_last, out_packet_bytes,
                      out_sequence_number, out_rtp_timestamp, out_run_last};
  assign ind_ok    = (out_packet_byte[4:0] == FU_A_TYPE) && (out_packet_bytes >= FRAG_W'(3));

  // A stalled output transaction holds.
  `FUA_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_beat), "stalled output changed")

  // A packet always ends on the last byte of a transaction.
  `FUA_ASSERT_SAME(a_last_ends_run, out_valid && out_packet_last, out_run_last, "packet end not at run end")

  // A one-byte packet reports a length of one.
  `FUA_ASSERT_SAME(a_single_len, out_valid && out_packet_first && out_packet_last, out_packet_bytes == FRAG_W'(1), "one-byte packet length wrong")

  // A packet start that is not the last result is an FU indicator.
  `FUA_ASSERT_SAME(a_fu_ind, out_valid && out_packet_first && !out_run_last, ind_ok, "bad FU indicator")

endmodule

bind h264_rtp_fu_a_packetizer_unit fua_checker u_fua_checker (.*);

/* tb/tb_h264_rtp_fu_a_packetizer_unit.sv */
// Self-checking testbench for the H.264 RTP FU-A packetizer: directed rows, then random NALs.
// Depends on fua_pkg and h264_rtp_fu_a_packetizer_unit; runs stand-alone.
`timescale 1ns / 1ps

module tb_h264_rtp_fu_a_packetizer_unit;
  import fua_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned ITEMS_PER_PHASE = 25;
  localparam int unsigned DIRECTED_ROWS = 33;

  // One payload byte on the result channel, as the block presents it.
  typedef struct packed {
    logic [BYTE_W-1:0] pkt_byte;
    logic              pkt_first;
    logic              pkt_last;
    logic [FRAG_W-1:0] pkt_bytes;
    logic [SEQ_W-1:0]  seq_num;
    logic [TS_W-1:0]   rtp_ts;
    logic              run_last;
  } pkt_beat_t;

  localparam pkt_beat_t NO_BEAT = '0;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // Directed stimulus row: either a register write or one NAL byte. For NAL bytes,
  // value carries nal_length; typed rows carry the single result expected.
  typedef struct {
    row_kind_t         kind;
    cfg_reg_t          reg_sel;
    logic [31:0]       value;
    logic [BYTE_W-1:0] nal_data;
    logic              nal_first;
    bit                typed;
    pkt_beat_t         beat;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_nal_byte = '0;
  logic                  in_nal_first = 1'b0;
  logic [LEN_W-1:0]      in_nal_length = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_packet_byte;
  logic                  out_packet_first;
  logic                  out_packet_last;
  logic [FRAG_W-1:0]     out_packet_bytes;
  logic [SEQ_W-1:0]      out_sequence_number;
  logic [TS_W-1:0]       out_rtp_timestamp;
  logic                  out_run_last;

  h264_rtp_fu_a_packetizer_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_nal_byte         (in_nal_byte),
    .in_nal_first        (in_nal_first),
    .in_nal_length       (in_nal_length),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_packet_byte     (out_packet_byte),
    .out_packet_first    (out_packet_first),
    .out_packet_last     (out_packet_last),
    .out_packet_bytes    (out_packet_bytes),
    .out_sequence_number (out_sequence_number),
    .out_rtp_timestamp   (out_rtp_timestamp),
    .out_run_last        (out_run_last)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Packetizer shadow: register copies and NAL state, advanced once per accepted byte.
  logic [FRAG_W-1:0] frag_size;
  logic [TS_W-1:0]   ts_step;
  logic [SEQ_W-1:0]  seq_start;
  logic [TS_W-1:0]   ts_start;
  logic              frag_mode;
  logic [LEN_W-1:0]  nal_remaining;
  logic [FRAG_W-1:0] frag_remaining;
  logic [BYTE_W-1:0] saved_hdr;
  logic [SEQ_W-1:0]  cur_seq;
  logic [TS_W-1:0]   cur_ts;
  logic              start_pending;
  logic [FRAG_W-1:0] pkt_len;

  pkt_beat_t step_payload[$];   // results of the byte just accepted
  pkt_beat_t payload_due[$];    // results still to come out, oldest first
  pkt_beat_t seen_beat;
  pkt_beat_t due_beat;
  stim_row_t directed_rows [DIRECTED_ROWS];

  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 59;
  int unsigned phase_items;
  int unsigned hold_left = 0;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;

  function automatic pkt_beat_t beat_of(input logic [BYTE_W-1:0] d, input logic f,
                                        input logic l);
    return '{d, f, l, pkt_len, cur_seq, cur_ts, 1'b0};
  endfunction

  // Close a single-NAL packet; SPS and PPS sent whole keep the timestamp.
  task automatic finish_single_nal();
    cur_seq = cur_seq + 1'b1;
    if (saved_hdr[4:0] != TYPE_SPS && saved_hdr[4:0] != TYPE_PPS)
      cur_ts = cur_ts + ts_step;
  endtask

  task automatic packetize_byte(input logic [BYTE_W-1:0] d, input logic f,
                                input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0]  nal_len;
    logic [FRAG_W-1:0] chunk;
    logic [BYTE_W-1:0] fu_hdr;
    pkt_beat_t         tail;
    step_payload.delete();
    nal_len = len;
    if (f) begin
      // Header byte: a zero length counts as one, any open NAL is dropped.
      if (nal_len == '0) nal_len = LEN_W'(1);
      saved_hdr = d;
      nal_remaining = nal_len - 1'b1;
      frag_remaining = '0;
      start_pending = 1'b1;
      if (nal_len <= {10'b0, frag_size}) begin
        frag_mode = 1'b0;
        pkt_len = nal_len[FRAG_W-1:0];
        step_payload.push_back(beat_of(d, 1'b1, nal_len == LEN_W'(1)));
        if (nal_remaining == '0) finish_single_nal();
      end else begin
        frag_mode = 1'b1;
        pkt_len = '0;
      end
    end else if (nal_remaining != '0) begin
      if (!frag_mode) begin
        nal_remaining = nal_remaining - 1'b1;
        step_payload.push_back(beat_of(d, 1'b0, nal_remaining == '0));
        if (nal_remaining == '0) finish_single_nal();
      end else begin
        if (frag_remaining == '0) begin
          // Open a fragment: size taken from the register as it stands now.
          chunk = (nal_remaining < {10'b0, frag_size}) ? nal_remaining[FRAG_W-1:0] : frag_size;
          fu_hdr = saved_hdr & TYPE_MASK;
          if (start_pending) fu_hdr = fu_hdr | START_BIT;
          if ({10'b0, chunk} == nal_remaining) fu_hdr = fu_hdr | END_BIT;
          start_pending = 1'b0;
          pkt_len = chunk + 14'd2;
          step_payload.push_back(beat_of((saved_hdr & NRI_MASK) | {3'b0, FU_A_TYPE},
                                         1'b1, 1'b0));
          step_payload.push_back(beat_of(fu_hdr, 1'b0, 1'b0));
          frag_remaining = chunk;
        end
        frag_remaining = frag_remaining - 1'b1;
        nal_remaining = nal_remaining - 1'b1;
        step_payload.push_back(beat_of(d, 1'b0, frag_remaining == '0));
        if (frag_remaining == '0) cur_seq = cur_seq + 1'b1;
        if (nal_remaining == '0) cur_ts = cur_ts + ts_step;
      end
    end
    if (step_payload.size() != 0) begin
      tail = step_payload.pop_back();
      tail.run_last = 1'b1;
      step_payload.push_back(tail);
    end
  endtask

  // Offer one NAL byte from a falling edge, idling at random first; hold until taken.
  task automatic send_byte(input logic [BYTE_W-1:0] d, input logic f,
                           input logic [LEN_W-1:0] len, input bit typed,
                           input pkt_beat_t beat);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_nal_byte   <= d;
    in_nal_first  <= f;
    in_nal_length <= len;
    do @(posedge clk); while (!in_ready);
    packetize_byte(d, f, len);
    if (typed) payload_due.push_back(beat);
    else foreach (step_payload[k]) payload_due.push_back(step_payload[k]);
  endtask

  // Drop valid and wait until every expected result is out, plus a margin for
  // header bytes that give no result.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (payload_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    logic [FRAG_W-1:0] fs;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAG_SIZE: begin
        // Keep the low 14 bits, then saturate into the legal range.
        fs = val[FRAG_W-1:0];
        if (fs < FRAG_MIN) fs = FRAG_MIN;
        if (fs > FRAG_MAX) fs = FRAG_MAX;
        frag_size = fs;
      end
      REG_TS_STEP: ts_step = val;
      REG_SEQ_START: begin
        seq_start = val[SEQ_W-1:0];
        cur_seq = seq_start;
      end
      REG_TS_START: begin
        ts_start = val;
        cur_ts = ts_start;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random NAL: mostly well-formed, some cut short (often with a huge length),
  // a few zero-length headers and stray bytes.
  task automatic send_random_nal();
    int unsigned       pick;
    int unsigned       nal_len;
    int unsigned       sent_len;
    int unsigned       fsz;
    logic [BYTE_W-1:0] hdr;
    logic [LEN_W-1:0]  len_field;
    pick = $urandom_range(0, 99);
    fsz = 32'(frag_size);
    if (pick < 8) begin
      // Stray byte: ignored unless a cut-short NAL is still open.
      send_byte(8'($urandom), 1'b0, 24'($urandom), 1'b0, NO_BEAT);
      return;
    end
    hdr = 8'($urandom);
    if ($urandom_range(0, 4) == 0) hdr[4:0] = $urandom_range(0, 1) ? TYPE_SPS : TYPE_PPS;
    case ($urandom_range(0, 3))
      0:       nal_len = fsz;
      1:       nal_len = fsz + 1;
      default: nal_len = $urandom_range(1, 3 * fsz + 2);
    endcase
    len_field = 24'(nal_len);
    sent_len = nal_len;
    if (pick < 11) begin
      len_field = '0;
      sent_len = 1;
    end else if (pick < 21) begin
      if ($urandom_range(0, 1)) len_field = 24'($urandom) | 24'h800000;
      sent_len = $urandom_range(1, nal_len);
    end
    send_byte(hdr, 1'b1, len_field, 1'b0, NO_BEAT);
    for (int unsigned i = 1; i < sent_len; i++)
      send_byte(8'($urandom), 1'b0, 24'($urandom), 1'b0, NO_BEAT);
    phase_items += sent_len;
  endtask

  // Receiver: drive ready at the falling edge; run the long hold-off once on request.
  always @(negedge clk) begin
    if (hold_request && !hold_done) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_beat = '{out_packet_byte, out_packet_first, out_packet_last, out_packet_bytes,
                    out_sequence_number, out_rtp_timestamp, out_run_last};
      if (payload_due.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: byte %02h first %0b last %0b len %0d seq %0d ts %08h rl %0b",
                   seen_beat.pkt_byte, seen_beat.pkt_first, seen_beat.pkt_last,
                   seen_beat.pkt_bytes, seen_beat.seq_num, seen_beat.rtp_ts, seen_beat.run_last);
      end else begin
        due_beat = payload_due.pop_front();
        if (seen_beat.pkt_byte !== due_beat.pkt_byte || seen_beat.pkt_first !== due_beat.pkt_first
            || seen_beat.pkt_last !== due_beat.pkt_last
            || seen_beat.pkt_bytes !== due_beat.pkt_bytes
            || seen_beat.seq_num !== due_beat.seq_num || seen_beat.rtp_ts !== due_beat.rtp_ts
            || seen_beat.run_last !== due_beat.run_last) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected byte %02h first %0b last %0b len %0d seq %0d ts %08h rl %0b",
                     due_beat.pkt_byte, due_beat.pkt_first, due_beat.pkt_last,
                     due_beat.pkt_bytes, due_beat.seq_num, due_beat.rtp_ts, due_beat.run_last);
            $display("  actual   byte %02h first %0b last %0b len %0d seq %0d ts %08h rl %0b",
                     seen_beat.pkt_byte, seen_beat.pkt_first, seen_beat.pkt_last,
                     seen_beat.pkt_bytes, seen_beat.seq_num, seen_beat.rtp_ts,
                     seen_beat.run_last);
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles = stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    // Reset values of the shadow registers and NAL state.
    frag_size      = FRAG_RESET;
    ts_step        = STEP_RESET;
    seq_start      = SEQ_RESET;
    ts_start       = TS_RESET;
    frag_mode      = 1'b0;
    nal_remaining  = '0;
    frag_remaining = '0;
    saved_hdr      = '0;
    cur_seq        = SEQ_RESET;
    cur_ts         = TS_RESET;
    start_pending  = 1'b0;
    pkt_len        = '0;

    // Directed rows: one-byte NALs straight after reset, SPS/PPS kept whole, a stray
    // byte, a zero length, saturated fragment sizes, sequence and timestamp wrap, a
    // NAL dropped by a new header, a one-fragment NAL with S and E together, and a
    // fragment size change in the middle of a NAL.
    directed_rows = '{
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd1, 8'h65, 1'b1, 1'b1,
        '{8'h65, 1'b1, 1'b1, 14'd1, 16'd0, 32'd0, 1'b1}},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd1, 8'h67, 1'b1, 1'b1,
        '{8'h67, 1'b1, 1'b1, 14'd1, 16'd1, 32'd3600, 1'b1}},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd2, 8'h68, 1'b1, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'h00FF_FFFF, 8'hAA, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'h00, 1'b1, 1'b1,
        '{8'h00, 1'b1, 1'b1, 14'd1, 16'd3, 32'd3600, 1'b1}},
      '{ROW_CFG, REG_FRAG_SIZE, 32'd0, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{ROW_CFG, REG_TS_STEP, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{ROW_CFG, REG_SEQ_START, 32'h0000_FFFF, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{ROW_CFG, REG_TS_START, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'h00FF_FFFF, 8'hFC, 1'b1, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd4, 8'h7C, 1'b1, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'h12, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'h34, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'h56, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd3, 8'h41, 1'b1, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'h9A, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'hBC, 1'b0, 1'b0, NO_BEAT},
      '{ROW_CFG, REG_FRAG_SIZE, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd2, 8'h61, 1'b1, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'hDE, 1'b0, 1'b0, NO_BEAT},
      '{ROW_CFG, REG_FRAG_SIZE, 32'd3, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd8, 8'h45, 1'b1, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'h01, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'h02, 1'b0, 1'b0, NO_BEAT},
      '{ROW_CFG, REG_FRAG_SIZE, 32'd2, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'h03, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'h04, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'h05, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'h06, 1'b0, 1'b0, NO_BEAT},
      '{ROW_ITEM, REG_FRAG_SIZE, 32'd0, 8'h07, 1'b0, 1'b0, NO_BEAT}
    };

    // Hold reset, then release it on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        send_byte(directed_rows[i].nal_data, directed_rows[i].nal_first,
                  directed_rows[i].value[LEN_W-1:0], directed_rows[i].typed,
                  directed_rows[i].beat);
      end
    end

    // Random phases: sender-light idling, then receiver-light, then none with one
    // long receiver hold-off so the queue fills and the input stalls.
    for (int phase = 0; phase < 3; phase++) begin
      settle();
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 12 : 0;
      // Upper data bits are noise: only the low 14 bits of a size write count.
      write_reg(REG_FRAG_SIZE, ($urandom & 32'hFFFF_C000) |
                ((phase == 0) ? 32'd1 : (phase == 1) ? $urandom_range(3, 7)
                                                     : $urandom_range(2, 6)));
      write_reg(REG_TS_STEP, (phase == 0) ? 32'd0 : $urandom);
      write_reg(REG_SEQ_START, (phase == 1) ? $urandom_range(65530, 65535) : $urandom);
      write_reg(REG_TS_START, $urandom);
      if (phase == 2) hold_request = 1'b1;
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) send_random_nal();
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
